// ----- rtl/cobs_frame_receiver_decoder_assert.svh -----
// Assertion macros for the COBS frame receiver and decoder.
`ifndef COBS_FRAME_RECEIVER_DECODER_ASSERT_SVH
`define COBS_FRAME_RECEIVER_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define COBSRX_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cobs decoder: same-cycle check failed");
`define COBSRX_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cobs decoder: next-cycle check failed");
`else
`define COBSRX_ASSERT_SAME(name, ante, cons)
`define COBSRX_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/cobsrx_pkg.sv -----
// Shared constants, state encoding and control types of the COBS decoder.
package cobsrx_pkg;
	localparam int FRAME_MAX = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int FILL_W = ADDR_W + 1;
	localparam logic [7:0] CODE_FULL = 8'hFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_EV,
		ST_EM_START,
		ST_EM_CRD,
		ST_EM_CODE,
		ST_EM_DRD,
		ST_EM_DATA,
		ST_EM_GAP,
		ST_FLUSH,
		ST_REJECT
	} state_t;

	typedef struct packed {
		logic store_wr;
		logic fill_clr;
		logic rd_clr;
		logic rd_inc;
		logic rd_add;
		logic nz_clr;
		logic nz_set;
		logic code_ld;
		logic cnt_dec;
		logic push_data;
		logic push_zero;
		logic flush;
		logic reject;
	} cmd_t;

	typedef struct packed {
		logic byte_zero;
		logic fill_full;
		logic rd_lt_len;
		logic chk_bad;
		logic chk_emits;
		logic nonempty;
		logic rdata_one;
		logic cnt_one;
		logic code_full;
	} stat_t;
endpackage

// ----- rtl/cobs_frame_receiver_decoder.sv -----
// Top level of the COBS frame receiver and decoder.
//
// Bytes enter on rx_byte and are taken at a clock edge where start is high and
// busy is low. A nonzero byte is written into the 64-entry frame store while busy
// stays low, so bytes may arrive back to back. A nonzero byte that finds the
// store full empties it and is dropped. A zero byte closes the frame: busy
// rises while the controller first walks the code bytes to check the frame,
// then walks the store again to emit the decoded bytes.
// The check pass reads each code byte and jumps to the next block. The decode
// pass reads each code byte and then each data byte through the registered store
// read, inserts a zero between blocks where one is due, and ends with the final beat.
// Each result beat is on valid, data_byte, last and status for one cycle; the
// final beat of a frame has last set. A rejected frame gives a single beat
// with status set and data_byte zero. Beats are held back by one register
// so that last can be set. Busy falls as the final beat is registered.
// The receiver cannot stall the result beats.
// Reset empties the store and leaves the block idle; no clearing pass is run.
`include "cobs_frame_receiver_decoder_assert.svh"
module cobs_frame_receiver_decoder import cobsrx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] rx_byte,
	output logic       valid,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       status
);
	cmd_t  cmd;
	stat_t stat;

	cobsrx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cobsrx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.cmd       (cmd),
		.stat      (stat),
		.valid     (valid),
		.data_byte (data_byte),
		.last      (last),
		.status    (status)
	);

	`COBSRX_ASSERT_SAME(a_reject_is_last, valid && status, last && (data_byte == 8'd0))
	`COBSRX_ASSERT_NEXT(a_delim_goes_busy, start && !busy && (rx_byte == 8'd0), busy)
	`COBSRX_ASSERT_SAME(a_one_command, 1'b1, $onehot0({cmd.push_data, cmd.push_zero, cmd.flush, cmd.reject}))
endmodule

// ----- rtl/cobsrx_ram.sv -----
// Generic simple dual-port RAM with registered read.
module cobsrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/cobsrx_ctrl.sv -----
// Controller state machine sequencing storage, frame check and decode.
module cobsrx_ctrl import cobsrx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  stat_t  stat,
	output cmd_t   cmd,
	output logic   busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (stat.byte_zero) begin
						cmd.rd_clr = 1'b1;
						cmd.nz_clr = 1'b1;
						state_d = ST_CHK_RD;
					end else if (stat.fill_full) begin
						cmd.fill_clr = 1'b1;
					end else begin
						cmd.store_wr = 1'b1;
					end
				end
			end
			ST_CHK_RD: begin
				if (stat.rd_lt_len) begin
					state_d = ST_CHK_EV;
				end else if (stat.nonempty) begin
					state_d = ST_EM_START;
				end else begin
					state_d = ST_REJECT;
				end
			end
			ST_CHK_EV: begin
				if (stat.chk_bad) begin
					state_d = ST_REJECT;
				end else begin
					cmd.rd_add = 1'b1;
					cmd.nz_set = stat.chk_emits;
					state_d = ST_CHK_RD;
				end
			end
			ST_EM_START: begin
				cmd.rd_clr = 1'b1;
				state_d = ST_EM_CRD;
			end
			ST_EM_CRD: begin
				state_d = ST_EM_CODE;
			end
			ST_EM_CODE: begin
				cmd.code_ld = 1'b1;
				cmd.rd_inc = 1'b1;
				state_d = stat.rdata_one ? ST_EM_GAP : ST_EM_DRD;
			end
			ST_EM_DRD: begin
				state_d = ST_EM_DATA;
			end
			ST_EM_DATA: begin
				cmd.push_data = 1'b1;
				cmd.rd_inc = 1'b1;
				cmd.cnt_dec = 1'b1;
				state_d = stat.cnt_one ? ST_EM_GAP : ST_EM_DRD;
			end
			ST_EM_GAP: begin
				cmd.push_zero = !stat.code_full && stat.rd_lt_len;
				state_d = stat.rd_lt_len ? ST_EM_CRD : ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				cmd.fill_clr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_REJECT: begin
				cmd.reject = 1'b1;
				cmd.fill_clr = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ----- rtl/cobsrx_dp.sv -----
// Datapath: frame store, read pointer, block counter and result registers.
module cobsrx_dp import cobsrx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  cmd_t       cmd,
	output stat_t      stat,
	output logic       valid,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       status
);
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] rd_q;
	logic [7:0]        code_q;
	logic [7:0]        cnt_q;
	logic              nz_q;
	logic [7:0]        pend_q;
	logic              pend_v_q;
	logic              valid_q;
	logic [7:0]        data_q;
	logic              last_q;
	logic              status_q;
	logic [7:0]        rdata;
	logic [8:0]        blk_end;
	logic [8:0]        len9;
	logic [7:0]        push_val;

	cobsrx_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.store_wr),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (rx_byte),
		.raddr (rd_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign blk_end = {{(9-FILL_W){1'b0}}, rd_q} + {1'b0, rdata};
	assign len9 = {{(9-FILL_W){1'b0}}, fill_q};
	assign push_val = cmd.push_data ? rdata : 8'd0;

	always_comb begin
		stat.byte_zero = (rx_byte == 8'd0);
		stat.fill_full = (fill_q >= FILL_W'(FRAME_MAX));
		stat.rd_lt_len = (rd_q < fill_q);
		stat.chk_bad = (rdata == 8'd0) || (blk_end > len9);
		stat.chk_emits = (rdata > 8'd1) || ((rdata != CODE_FULL) && (blk_end < len9));
		stat.nonempty = nz_q;
		stat.rdata_one = (rdata == 8'd1);
		stat.cnt_one = (cnt_q == 8'd1);
		stat.code_full = (code_q == CODE_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_q <= '0;
			nz_q <= 1'b0;
			pend_v_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.store_wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.rd_clr) begin
				rd_q <= '0;
			end else if (cmd.rd_add) begin
				rd_q <= blk_end[FILL_W-1:0];
			end else if (cmd.rd_inc) begin
				rd_q <= rd_q + 1'b1;
			end
			if (cmd.nz_clr) begin
				nz_q <= 1'b0;
			end else if (cmd.nz_set) begin
				nz_q <= 1'b1;
			end
			if (cmd.push_data || cmd.push_zero) begin
				valid_q <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				valid_q <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (cmd.reject) begin
				valid_q <= 1'b1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.code_ld) begin
			code_q <= rdata;
			cnt_q <= rdata - 8'd1;
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - 8'd1;
		end
		if (cmd.push_data || cmd.push_zero) begin
			pend_q <= push_val;
			data_q <= pend_q;
			last_q <= 1'b0;
			status_q <= 1'b0;
		end else if (cmd.flush) begin
			data_q <= pend_q;
			last_q <= 1'b1;
			status_q <= 1'b0;
		end else if (cmd.reject) begin
			data_q <= 8'd0;
			last_q <= 1'b1;
			status_q <= 1'b1;
		end
	end

	assign valid = valid_q;
	assign data_byte = data_q;
	assign last = last_q;
	assign status = status_q;
endmodule
